### src/phc_pkg.sv
package phc_pkg;

  localparam int unsigned HdrWords = 20;
  localparam logic [31:0] MantMask = 32'h007fffff;

  typedef logic [31:0] word_t;

  typedef enum logic [2:0] {
    SEL_STORED  = 3'b001,
    SEL_BLOCK2  = 3'b010,
    SEL_BLOCK3  = 3'b100
  } msg_sel_t;

  typedef struct packed {
    logic     load_iv;
    logic     init_state;
    logic     init_iv;
    logic     round_en;
    logic     finish;
    msg_sel_t msel;
    logic     save_first;
    logic     compare;
  } dp_cmd_t;

  typedef struct packed {
    logic last_round;
    logic pow_ok;
  } dp_sts_t;

  function automatic word_t k256(input logic [5:0] i);
    word_t k [64] = '{
      32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
      32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
      32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
      32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
      32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
      32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
      32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
      32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
      32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
      32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
      32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
    return k[i];
  endfunction

  function automatic word_t iv256(input logic [2:0] i);
    word_t v [8] = '{32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
                     32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};
    return v[i];
  endfunction

endpackage

### src/phc_ctrl.sv
module phc_ctrl
  import phc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       last_word,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       length_error,
  output logic       pow_ok,
  output logic       wr_en,
  output logic       tgt_en,
  output logic [4:0] wr_idx,
  output dp_cmd_t    cmd,
  input  dp_sts_t    sts
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_C1     = 7'b0000010,
    S_C2     = 7'b0000100,
    S_C2SAVE = 7'b0001000,
    S_C3     = 7'b0010000,
    S_C3FIN  = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_t;

  state_t      state, state_next;
  logic [4:0]  word_count;
  logic        in_fire;
  logic        ok_r, lerr_r;

  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = (state == S_OUT);
  assign pow_ok    = ok_r;
  assign length_error = lerr_r;
  assign wr_en  = in_fire && (word_count < 5'(HdrWords));
  assign tgt_en = in_fire && (word_count == 5'd18);
  assign wr_idx = word_count;

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.msel = SEL_STORED;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (last_word) begin
            if (word_count == 5'd19) begin
              state_next = S_C2;
              cmd.init_state = 1'b1;
            end else begin
              // A header of the wrong length still clears the chaining state.
              cmd.load_iv = 1'b1;
              state_next = S_OUT;
            end
          end else if (word_count == 5'd15) begin
            state_next = S_C1;
            cmd.init_state = 1'b1;
          end
        end
      end
      S_C1: begin
        cmd.round_en = 1'b1;
        if (sts.last_round) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_C2: begin
        cmd.round_en = 1'b1;
        cmd.msel = SEL_BLOCK2;
        if (sts.last_round) begin
          cmd.finish = 1'b1;
          state_next = S_C2SAVE;
        end
      end
      S_C2SAVE: begin
        cmd.save_first = 1'b1;
        cmd.init_iv = 1'b1;
        state_next = S_C3;
      end
      S_C3: begin
        cmd.round_en = 1'b1;
        cmd.msel = SEL_BLOCK3;
        if (sts.last_round) begin
          cmd.finish = 1'b1;
          state_next = S_C3FIN;
        end
      end
      S_C3FIN: begin
        cmd.compare = 1'b1;
        cmd.load_iv = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      word_count <= '0;
      ok_r       <= 1'b0;
      lerr_r     <= 1'b0;
    end else begin
      state <= state_next;
      if (in_fire) begin
        if (last_word) begin
          word_count <= '0;
          ok_r   <= 1'b0;
          lerr_r <= (word_count != 5'd19);
        end else if (word_count < 5'(HdrWords)) begin
          word_count <= word_count + 5'd1;
        end
      end
      if (cmd.compare) ok_r <= sts.pow_ok;
    end
  end

endmodule

### src/phc_datapath.sv
module phc_datapath
  import phc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       wr_en,
  input  logic       tgt_en,
  input  logic [4:0] wr_idx,
  input  word_t      header_word,
  input  dp_cmd_t    cmd,
  output dp_sts_t    sts
);

  word_t      msg [16];
  word_t      w [16];
  word_t      h [8];
  word_t      v [8];
  word_t      dig [8];
  word_t      tgt;
  logic [5:0] rnd;
  word_t      blk_w;
  word_t      wt;
  word_t      s0, s1, big1, big0, chv, mjv, t1, t2;
  logic       in_prefix;
  logic [255:0] hash_le, tgt_le;
  logic [7:0] ex;
  logic [22:0] mant;

  // Message word for rounds 0..15, by block kind.
  always_comb begin
    blk_w = '0;
    case (cmd.msel)
      SEL_STORED: blk_w = msg[rnd[3:0]];
      SEL_BLOCK2: begin
        if (rnd[3:0] < 4'd4) blk_w = msg[rnd[3:0]];
        else if (rnd[3:0] == 4'd4) blk_w = 32'h80000000;
        else if (rnd[3:0] == 4'd15) blk_w = 32'd640;
      end
      SEL_BLOCK3: begin
        if (rnd[3:0] < 4'd8) blk_w = dig[rnd[2:0]];
        else if (rnd[3:0] == 4'd8) blk_w = 32'h80000000;
        else if (rnd[3:0] == 4'd15) blk_w = 32'd256;
      end
      default: blk_w = '0;
    endcase
  end

  assign in_prefix = (rnd < 6'd16);
  assign s0 = {w[1][6:0], w[1][31:7]} ^ {w[1][17:0], w[1][31:18]} ^ (w[1] >> 3);
  assign s1 = {w[14][16:0], w[14][31:17]} ^ {w[14][18:0], w[14][31:19]} ^ (w[14] >> 10);
  assign wt = in_prefix ? blk_w : (w[0] + s0 + w[9] + s1);

  assign big1 = {v[4][5:0], v[4][31:6]} ^ {v[4][10:0], v[4][31:11]}
              ^ {v[4][24:0], v[4][31:25]};
  assign big0 = {v[0][1:0], v[0][31:2]} ^ {v[0][12:0], v[0][31:13]}
              ^ {v[0][21:0], v[0][31:22]};
  assign chv  = (v[4] & v[5]) ^ (~v[4] & v[6]);
  assign mjv  = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
  assign t1   = v[7] + big1 + chv + k256(rnd) + wt;
  assign t2   = big0 + mjv;

  assign sts.last_round = (rnd == 6'd63);

  // Byte k of the digest is byte (3 - k%4) of state word k/4.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      for (int b = 0; b < 4; b++) begin
        hash_le[(4*i+b)*8 +: 8] = h[i][(3-b)*8 +: 8];
      end
    end
  end

  assign ex   = tgt[31:24];
  assign mant = tgt[22:0];
  always_comb begin
    tgt_le = '0;
    if (ex <= 8'd3) begin
      tgt_le[22:0] = mant >> (5'(3 - ex) * 5'd8);
    end else begin
      for (int i = 0; i < 3; i++) begin
        if (32'(ex) - 32'd3 + 32'(i) < 32'd32)
          tgt_le[(32'(ex) - 32'd3 + 32'(i))*8 +: 8] = 8'({1'b0, mant} >> (8*i));
      end
    end
  end
  assign sts.pow_ok = (hash_le <= tgt_le);

  always_ff @(posedge clk) begin
    if (wr_en) msg[wr_idx[3:0]] <= {header_word[7:0], header_word[15:8],
                                   header_word[23:16], header_word[31:24]};
    if (cmd.save_first) dig <= h;
    if (cmd.init_state) begin
      v   <= h;
      rnd <= '0;
    end else if (cmd.init_iv) begin
      for (int i = 0; i < 8; i++) v[i] <= iv256(3'(i));
      rnd <= '0;
    end else if (cmd.round_en) begin
      v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
      v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= wt;
      rnd <= rnd + 6'd1;
    end
    if (rst) begin
      tgt <= '0;
      for (int i = 0; i < 8; i++) h[i] <= iv256(3'(i));
    end else begin
      if (cmd.load_iv) tgt <= '0;
      else if (tgt_en) tgt <= header_word;
      if (cmd.load_iv || cmd.init_iv) begin
        for (int i = 0; i < 8; i++) h[i] <= iv256(3'(i));
      end else if (cmd.finish) begin
        // The last round lands in the same cycle, so add its outputs directly.
        h[0] <= h[0] + t1 + t2;
        h[1] <= h[1] + v[0];
        h[2] <= h[2] + v[1];
        h[3] <= h[3] + v[2];
        h[4] <= h[4] + v[3] + t1;
        h[5] <= h[5] + v[4];
        h[6] <= h[6] + v[5];
        h[7] <= h[7] + v[6];
      end
    end
  end

endmodule

### src/pow_header_check.sv
// Channel | Signals                               | Direction
// in      | in_valid, in_ready, header_word, last_word | into block
// out     | out_valid, out_ready, pow_ok, length_error | out of block
//
// Word 15 starts a 64-round compression that holds in_ready low until
// it ends. The final word starts two more, the first followed by a
// save step and the second by a compare step, all set by the single
// shared round unit. A wrong-length final word reports in the next
// cycle. The result holds until its transfer. Reset is synchronous.
module pow_header_check
  import phc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] header_word,
  input  logic        last_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        pow_ok,
  output logic        length_error
);

  dp_cmd_t    cmd;
  dp_sts_t    sts;
  logic       wr_en, tgt_en;
  logic [4:0] wr_idx;

  phc_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .last_word, .out_valid, .out_ready,
    .length_error, .pow_ok, .wr_en, .tgt_en, .wr_idx, .cmd, .sts
  );

  phc_datapath u_dp (
    .clk, .rst, .wr_en, .tgt_en, .wr_idx, .header_word, .cmd, .sts
  );

endmodule
